// ===== hdl/bsfr_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the byte-stuffed
// frame receiver. Used by bsfr_ctrl, bsfr_dpath and the top level.
`default_nettype none

package bsfr_pkg;

    localparam int PAYLOAD_MAX_DEF = 32;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 7;
    localparam int CMD_W  = 7;
    localparam int CNT_W  = 6;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPED_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPED_ESCAPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED       = 3'd5;

    // configuration reset values
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST    = 7'd1;
    localparam logic [BYTE_W-1:0] FRAME_END_RST      = 8'hC0;
    localparam logic [BYTE_W-1:0] ESCAPE_RST         = 8'hDB;
    localparam logic [BYTE_W-1:0] ESCAPED_END_RST    = 8'hDC;
    localparam logic [BYTE_W-1:0] ESCAPED_ESCAPE_RST = 8'hDD;
    localparam logic [BYTE_W-1:0] CRC_SEED_RST       = 8'hDE;

    // reflected Dallas CRC-8 step constants
    localparam logic [BYTE_W-1:0] CRC_XOR  = 8'h18;
    localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [BYTE_W-1:0] CRC_MASK = 8'h7F;

    // controller to datapath
    typedef struct packed {
        logic prev_we;
        logic crc_we;
        logic crc_start;
        logic crc_addr;
        logic cmd_we;
        logic count_we;
        logic data_we;
        logic emit_err;
        logic emit_hdr;
        logic emit_pay;
        logic rd_start;
    } bsfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic line_err;
        logic is_end;
        logic is_esc;
        logic prev_esc;
        logic esc_bad;
        logic dec_bit7;
        logic addr_ok;
        logic count_ok;
        logic fill_more;
        logic crc_ok;
        logic count_zero;
        logic pay_last;
        logic out_free;
    } bsfr_sts_t;

    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc_in,
                                                      input logic [BYTE_W-1:0] data_in);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = ((c ^ CRC_XOR) >> 1) | CRC_TOP;
            end
            else
            begin
                c = (c >> 1) & CRC_MASK;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bsfr_ctrl.sv =====
// Frame parsing state machine of the byte-stuffed frame receiver.
// Depends on bsfr_pkg for the command and status structs.
`default_nettype none

module bsfr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bsfr_pkg::bsfr_sts_t sts,
    output bsfr_pkg::bsfr_cmd_t     cmd
);
    import bsfr_pkg::*;

    localparam logic [2:0] ST_WAIT_END = 3'd0;
    localparam logic [2:0] ST_ADDR     = 3'd1;
    localparam logic [2:0] ST_CMD      = 3'd2;
    localparam logic [2:0] ST_COUNT    = 3'd3;
    localparam logic [2:0] ST_DATA     = 3'd4;
    localparam logic [2:0] ST_EMIT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       parse_state;
    logic       take;

    always_comb
    begin
        parse_state = (state_reg == ST_WAIT_END) || (state_reg == ST_ADDR) ||
                      (state_reg == ST_CMD) || (state_reg == ST_COUNT) ||
                      (state_reg == ST_DATA);
        in_ready    = parse_state && sts.out_free;
        take        = in_valid && in_ready;
        cmd         = '0;
        state_next  = state_reg;

        case (state_reg)
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_pay = 1'b1;
                    if (sts.pay_last)
                    begin
                        state_next = ST_WAIT_END;
                    end
                end
            end
            ST_WAIT_END, ST_ADDR, ST_CMD, ST_COUNT, ST_DATA:
            begin
                if (take)
                begin
                    if (sts.line_err)
                    begin
                        cmd.emit_err = 1'b1;
                        state_next   = ST_WAIT_END;
                    end
                    else if (sts.is_end)
                    begin
                        // frame end restarts a frame from any parsing state
                        cmd.prev_we   = 1'b1;
                        cmd.crc_we    = 1'b1;
                        cmd.crc_start = 1'b1;
                        state_next    = ST_ADDR;
                    end
                    else if (state_reg != ST_WAIT_END)
                    begin
                        cmd.prev_we = 1'b1;
                        if (sts.esc_bad)
                        begin
                            cmd.emit_err = 1'b1;
                            state_next   = ST_WAIT_END;
                        end
                        else if (!sts.prev_esc && sts.is_esc)
                        begin
                            // hold: wait for the second byte of the pair
                        end
                        else if ((state_reg == ST_ADDR) && sts.dec_bit7)
                        begin
                            if (sts.addr_ok)
                            begin
                                cmd.crc_we   = 1'b1;
                                cmd.crc_addr = 1'b1;
                                state_next   = ST_CMD;
                            end
                            else
                            begin
                                state_next = ST_WAIT_END;
                            end
                        end
                        else if ((state_reg == ST_ADDR) || (state_reg == ST_CMD))
                        begin
                            if (sts.dec_bit7)
                            begin
                                cmd.emit_err = 1'b1;
                                state_next   = ST_WAIT_END;
                            end
                            else
                            begin
                                cmd.cmd_we = 1'b1;
                                cmd.crc_we = 1'b1;
                                state_next = ST_COUNT;
                            end
                        end
                        else if (state_reg == ST_COUNT)
                        begin
                            if (!sts.count_ok)
                            begin
                                cmd.emit_err = 1'b1;
                                state_next   = ST_WAIT_END;
                            end
                            else
                            begin
                                cmd.count_we = 1'b1;
                                cmd.crc_we   = 1'b1;
                                state_next   = ST_DATA;
                            end
                        end
                        else if (sts.fill_more)
                        begin
                            cmd.data_we = 1'b1;
                            cmd.crc_we  = 1'b1;
                        end
                        else if (!sts.crc_ok)
                        begin
                            cmd.emit_err = 1'b1;
                            state_next   = ST_WAIT_END;
                        end
                        else
                        begin
                            cmd.emit_hdr = 1'b1;
                            cmd.rd_start = 1'b1;
                            state_next   = sts.count_zero ? ST_WAIT_END : ST_EMIT;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT_END;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_END;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bsfr_dpath.sv =====
// Datapath of the byte-stuffed frame receiver: configuration registers,
// unstuffing, CRC-8, payload store and output register. Depends on bsfr_pkg.
`default_nettype none

module bsfr_dpath #(
    parameter int PAYLOAD_MAX = bsfr_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]      cfg_data,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]      rx_byte,
    input  wire logic                             line_error,
    input  wire bsfr_pkg::bsfr_cmd_t              cmd,
    output bsfr_pkg::bsfr_sts_t                   sts,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [bsfr_pkg::KIND_W-1:0]           out_kind,
    output logic [bsfr_pkg::CMD_W-1:0]            out_command,
    output logic [bsfr_pkg::CNT_W-1:0]            out_length,
    output logic [bsfr_pkg::BYTE_W-1:0]           out_payload,
    output logic                                  out_last
);
    import bsfr_pkg::*;

    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [ADDR_W-1:0] own_address_reg;
    logic [BYTE_W-1:0] frame_end_reg;
    logic [BYTE_W-1:0] escape_reg;
    logic [BYTE_W-1:0] escaped_end_reg;
    logic [BYTE_W-1:0] escaped_escape_reg;
    logic [BYTE_W-1:0] crc_seed_reg;

    logic [BYTE_W-1:0] prev_reg;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic [CMD_W-1:0]  pend_cmd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  rd_idx_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] store_mem [PAYLOAD_MAX];

    logic [BYTE_W-1:0] dec_byte;
    logic [BYTE_W-1:0] crc_base;
    logic [BYTE_W-1:0] crc_data;
    logic [ADDR_W-1:0] addr_field;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [CMD_W-1:0]  out_command_reg;
    logic [CNT_W-1:0]  out_length_reg;
    logic [BYTE_W-1:0] out_payload_reg;
    logic              out_last_reg;

    // undo the escape pair and form the status flags for the controller
    always_comb
    begin
        sts.prev_esc = (prev_reg == escape_reg);
        dec_byte     = rx_byte;
        sts.esc_bad  = 1'b0;
        if (sts.prev_esc)
        begin
            if (rx_byte == escaped_escape_reg)
            begin
                dec_byte = escape_reg;
            end
            else if (rx_byte == escaped_end_reg)
            begin
                dec_byte = frame_end_reg;
            end
            else
            begin
                sts.esc_bad = 1'b1;
            end
        end
        addr_field     = dec_byte[ADDR_W-1:0];
        sts.line_err   = line_error;
        sts.is_end     = (rx_byte == frame_end_reg);
        sts.is_esc     = (rx_byte == escape_reg);
        sts.dec_bit7   = dec_byte[BYTE_W-1];
        sts.addr_ok    = (addr_field == '0) || (addr_field == own_address_reg);
        sts.count_ok   = (dec_byte <= BYTE_W'(PAYLOAD_MAX));
        sts.fill_more  = (fill_reg < count_reg) && (fill_reg < CNT_W'(PAYLOAD_MAX));
        sts.crc_ok     = (dec_byte == crc_reg);
        sts.count_zero = (count_reg == '0);
        sts.pay_last   = ((rd_idx_reg + CNT_W'(1)) == count_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        crc_base = cmd.crc_start ? crc_seed_reg : crc_reg;
        if (cmd.crc_start)
        begin
            crc_data = rx_byte;
        end
        else if (cmd.crc_addr)
        begin
            crc_data = {1'b0, addr_field};
        end
        else
        begin
            crc_data = dec_byte;
        end
        crc_next = crc8_update(crc_base, crc_data);

        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.emit_pay)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        else
        begin
            rd_idx_next = rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= OWN_ADDRESS_RST;
            frame_end_reg      <= FRAME_END_RST;
            escape_reg         <= ESCAPE_RST;
            escaped_end_reg    <= ESCAPED_END_RST;
            escaped_escape_reg <= ESCAPED_ESCAPE_RST;
            crc_seed_reg       <= CRC_SEED_RST;
            prev_reg           <= '0;
            crc_reg            <= '0;
            pend_cmd_reg       <= '0;
            count_reg          <= '0;
            fill_reg           <= '0;
            rd_idx_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_ADDRESS:    own_address_reg    <= cfg_data[ADDR_W-1:0];
                    CFG_FRAME_END:      frame_end_reg      <= cfg_data;
                    CFG_ESCAPE:         escape_reg         <= cfg_data;
                    CFG_ESCAPED_END:    escaped_end_reg    <= cfg_data;
                    CFG_ESCAPED_ESCAPE: escaped_escape_reg <= cfg_data;
                    CFG_CRC_SEED:       crc_seed_reg       <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.prev_we)
            begin
                prev_reg <= rx_byte;
            end
            if (cmd.crc_we)
            begin
                crc_reg <= crc_next;
            end
            if (cmd.cmd_we)
            begin
                pend_cmd_reg <= dec_byte[CMD_W-1:0];
            end
            if (cmd.count_we)
            begin
                count_reg <= dec_byte[CNT_W-1:0];
                fill_reg  <= '0;
            end
            else if (cmd.data_we)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            rd_idx_reg <= rd_idx_next;
            if (cmd.emit_err || cmd.emit_hdr || cmd.emit_pay)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload store; the read data register holds the entry at the current read index
    always_ff @(posedge clk)
    begin
        if (cmd.data_we)
        begin
            store_mem[fill_reg[IDX_W-1:0]] <= dec_byte;
        end
        rd_data_reg <= store_mem[rd_idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_err)
        begin
            out_kind_reg    <= KIND_ERROR;
            out_command_reg <= '0;
            out_length_reg  <= '0;
            out_payload_reg <= '0;
            out_last_reg    <= 1'b1;
        end
        else if (cmd.emit_hdr)
        begin
            out_kind_reg    <= KIND_HEADER;
            out_command_reg <= pend_cmd_reg;
            out_length_reg  <= count_reg;
            out_payload_reg <= '0;
            out_last_reg    <= sts.count_zero;
        end
        else if (cmd.emit_pay)
        begin
            out_kind_reg    <= KIND_PAYLOAD;
            out_command_reg <= '0;
            out_length_reg  <= count_reg;
            out_payload_reg <= rd_data_reg;
            out_last_reg    <= sts.pay_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_command = out_command_reg;
    assign out_length  = out_length_reg;
    assign out_payload = out_payload_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/byte_stuffed_frame_receiver_crc8.sv =====
// Top level of the byte-stuffed frame receiver with CRC-8 check.
// Joins bsfr_ctrl and bsfr_dpath; depends on bsfr_pkg.
//
// Usage:
//   s_axis carries one received serial byte per beat (tdata) with its
//   line-error flag (tuser). m_axis carries results: a header beat
//   (command, length) of a good frame followed by its payload beats, or
//   one error beat. tlast marks the final beat of each run.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only
//   while the block is idle.
//   A result shows on m_axis in the cycle after the byte that causes it is
//   taken; bytes are taken back to back unless payload is being emitted or
//   m_axis is stalled. After a good CRC byte the payload runs out of the
//   single-read-port payload store at one beat per cycle while m_axis takes
//   each beat; s_axis is held off until the last payload beat is emitted.
//   While m_axis is stalled the output register holds its beat, and
//   s_axis_tready stays low until the beat is taken.
//   Reset brings the configuration to its defaults and the parser back to
//   hunting for a frame-end byte; no clearing pass is needed.
`default_nettype none

module byte_stuffed_frame_receiver_crc8 #(
    parameter int PAYLOAD_MAX = bsfr_pkg::PAYLOAD_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [bsfr_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                               s_axis_tuser,  // [0] line_error
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [6:0] command, [12:7] length, [20:13] payload, [23:21] zero
    output logic [bsfr_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    output logic [bsfr_pkg::KIND_W-1:0]             m_axis_tuser,  // [1:0] result_kind
    output logic                                    m_axis_tlast
);
    import bsfr_pkg::*;

    bsfr_cmd_t         cmd;
    bsfr_sts_t         sts;
    logic [CMD_W-1:0]  out_command;
    logic [CNT_W-1:0]  out_length;
    logic [BYTE_W-1:0] out_payload;

    bsfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsfr_dpath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_byte     (s_axis_tdata[BYTE_W-1:0]),
        .line_error  (s_axis_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_kind    (m_axis_tuser),
        .out_command (out_command),
        .out_length  (out_length),
        .out_payload (out_payload),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_payload, out_length, out_command};

endmodule

`default_nettype wire
